// ----- src/cht_pkg.sv -----
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and codes for the cuckoo hash table: request and result
// payloads, command and status codes, controller states and datapath ops.
// ----------------------------------------------------------------------------
package cht_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_STASHED   = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  localparam logic [1:0] REG_SALT_FIRST  = 2'd0;
  localparam logic [1:0] REG_SALT_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_KICKS   = 2'd2;

  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic        found;
    logic [31:0] read_value;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH_A,
    S_RD_A,
    S_HASH_B,
    S_RD_B,
    S_PROBE,
    S_K_HASH1,
    S_K_RD1,
    S_K_EV1,
    S_K_HASH2,
    S_K_RD2,
    S_K_EV2,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_HASH_A,
    OP_RD_A,
    OP_HASH_B,
    OP_RD_B,
    OP_PROBE,
    OP_K_HASH1,
    OP_K_RD1,
    OP_K_EV1,
    OP_K_HASH2,
    OP_K_RD2,
    OP_K_EV2,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic clear_done;
    logic kick;
    logic slot_free;
    logic limit;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- src/cht_ctrl.sv -----
// ----------------------------------------------------------------------------
// cht_ctrl
// Sequencer for clearing, probing and the displacement loop.
// ----------------------------------------------------------------------------
module cht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cht_pkg::dp_stat_t stat,
  output cht_pkg::op_t      op
);
  import cht_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:   if (stat.clear_done) state_nxt = S_IDLE;
      S_IDLE:    if (in_valid) state_nxt = S_HASH_A;
      S_HASH_A:  state_nxt = S_RD_A;
      S_RD_A:    state_nxt = S_HASH_B;
      S_HASH_B:  state_nxt = S_RD_B;
      S_RD_B:    state_nxt = S_PROBE;
      S_PROBE:   state_nxt = stat.kick ? S_K_HASH1 : S_DONE;
      S_K_HASH1: state_nxt = S_K_RD1;
      S_K_RD1:   state_nxt = S_K_EV1;
      S_K_EV1:   state_nxt = stat.slot_free ? S_DONE : S_K_HASH2;
      S_K_HASH2: state_nxt = S_K_RD2;
      S_K_RD2:   state_nxt = S_K_EV2;
      S_K_EV2:   state_nxt = (stat.slot_free || stat.limit) ? S_DONE : S_K_HASH1;
      S_DONE:    if (stat.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    op       = OP_NONE;
    case (state_r)
      S_CLEAR:   op = OP_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LOAD;
      end
      S_HASH_A:  op = OP_HASH_A;
      S_RD_A:    op = OP_RD_A;
      S_HASH_B:  op = OP_HASH_B;
      S_RD_B:    op = OP_RD_B;
      S_PROBE:   op = OP_PROBE;
      S_K_HASH1: op = OP_K_HASH1;
      S_K_RD1:   op = OP_K_RD1;
      S_K_EV1:   op = OP_K_EV1;
      S_K_HASH2: op = OP_K_HASH2;
      S_K_RD2:   op = OP_K_RD2;
      S_K_EV2:   op = OP_K_EV2;
      S_DONE:    if (stat.out_free) op = OP_OUT;
      default:   op = OP_NONE;
    endcase
  end

endmodule

// ----- src/cht_dp.sv -----
// ----------------------------------------------------------------------------
// cht_dp
// Table memory, hash multiplier, stash, config registers and result register.
// ----------------------------------------------------------------------------
module cht_dp #(
  parameter int HALF_DEPTH = 1024,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cht_pkg::op_t      op,
  output cht_pkg::dp_stat_t stat,
  input  cht_pkg::req_t     in_data,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cht_pkg::rsp_t     out_data
);
  import cht_pkg::*;

  localparam int IB    = $clog2(HALF_DEPTH + 1) - 1;
  localparam int AW    = IB + 1;
  localparam int KW    = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VW    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int DEPTH = 2 * (2 ** IB);

  typedef struct packed {
    logic          valid;
    logic [KW-1:0] key;
    logic [VW-1:0] val;
  } entry_t;

  entry_t mem [DEPTH];
  entry_t rd_r;

  logic [31:0]   salt_first_r, salt_second_r;
  logic [10:0]   max_kicks_r;
  logic [AW-1:0] clr_cnt_r;
  cmd_t          cmd_r;
  logic [KW-1:0] cur_key_r, tmp_key_r, stash_key_r;
  logic [VW-1:0] cur_val_r, tmp_val_r, stash_val_r, val_a_r;
  logic          stash_valid_r, hit_a_r;
  logic [31:0]   prod_r;
  logic [AW-1:0] addr_a_r, addr_b_r;
  logic [10:0]   rounds_r;
  status_t       res_status_r;
  logic          res_found_r;
  logic [VW-1:0] res_val_r;
  logic          out_valid_r;
  rsp_t          out_data_r;

  logic [IB-1:0] idx;
  logic [31:0]   mul_x;
  logic          mul_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          hit_b, stash_hit, dup;
  logic [10:0]   kicks_eff, rounds_inc;
  status_t       probe_status;
  logic          probe_found;
  logic [VW-1:0] probe_val;

  assign idx        = prod_r[31 -: IB];
  assign hit_b      = rd_r.valid && (rd_r.key == cur_key_r);
  assign stash_hit  = stash_valid_r && (stash_key_r == cur_key_r);
  assign dup        = hit_a_r || hit_b || stash_hit;
  assign kicks_eff  = (max_kicks_r == 11'd0) ? 11'd1 : max_kicks_r;
  assign rounds_inc = rounds_r + 11'd1;

  assign stat.clear_done = (clr_cnt_r == AW'(DEPTH - 1));
  assign stat.kick       = (cmd_r == CMD_INSERT) && !dup && !stash_valid_r;
  assign stat.slot_free  = !rd_r.valid;
  assign stat.limit      = (rounds_inc >= kicks_eff);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    mul_en = 1'b1;
    case (op)
      OP_HASH_A, OP_K_HASH1: mul_x = 32'(cur_key_r) ^ salt_first_r;
      OP_HASH_B:             mul_x = 32'(cur_key_r) ^ salt_second_r;
      OP_K_HASH2:            mul_x = 32'(tmp_key_r) ^ salt_second_r;
      default: begin
        mul_x  = '0;
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    rd_en   = 1'b1;
    case (op)
      OP_RD_A, OP_K_RD1: rd_addr = {1'b0, idx};
      OP_RD_B, OP_K_RD2: rd_addr = {1'b1, idx};
      default: begin
        rd_addr = '0;
        rd_en   = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_a_r;
    wr_data = '0;
    case (op)
      OP_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
      end
      OP_PROBE: begin
        if (cmd_r == CMD_REMOVE && hit_a_r) begin
          wr_en = 1'b1;
        end else if (cmd_r == CMD_REMOVE && hit_b) begin
          wr_en   = 1'b1;
          wr_addr = addr_b_r;
        end
      end
      OP_K_EV1: begin
        wr_en   = 1'b1;
        wr_data = '{valid: 1'b1, key: cur_key_r, val: cur_val_r};
      end
      OP_K_EV2: begin
        wr_en   = 1'b1;
        wr_addr = addr_b_r;
        wr_data = '{valid: 1'b1, key: tmp_key_r, val: tmp_val_r};
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_comb begin
    probe_status = ST_NOT_FOUND;
    probe_found  = 1'b0;
    probe_val    = '0;
    case (cmd_r)
      CMD_INSERT: begin
        if (dup) begin
          probe_status = ST_EXISTS;
        end else if (stash_valid_r) begin
          probe_status = ST_FULL;
        end
      end
      CMD_LOOKUP, CMD_REMOVE: begin
        if (hit_a_r) begin
          probe_status = ST_OK;
          probe_found  = 1'b1;
          probe_val    = val_a_r;
        end else if (hit_b) begin
          probe_status = ST_OK;
          probe_found  = 1'b1;
          probe_val    = rd_r.val;
        end else if (stash_hit) begin
          probe_status = ST_OK;
          probe_found  = 1'b1;
          probe_val    = stash_val_r;
        end
      end
      default: probe_status = ST_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      salt_first_r  <= 32'd1;
      salt_second_r <= 32'd2;
      max_kicks_r   <= 11'd64;
      clr_cnt_r     <= '0;
      stash_valid_r <= 1'b0;
      stash_key_r   <= '0;
      stash_val_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SALT_FIRST:  salt_first_r  <= cfg_data;
          REG_SALT_SECOND: salt_second_r <= cfg_data;
          REG_MAX_KICKS:   max_kicks_r   <= cfg_data[10:0];
          default:         max_kicks_r   <= max_kicks_r;
        endcase
      end
      if (op == OP_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (op == OP_PROBE && cmd_r == CMD_REMOVE && !hit_a_r && !hit_b && stash_hit) begin
        stash_valid_r <= 1'b0;
      end
      if (op == OP_K_EV2 && rd_r.valid && stat.limit) begin
        stash_valid_r <= 1'b1;
        stash_key_r   <= rd_r.key;
        stash_val_r   <= rd_r.val;
      end
      if (op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= mul_x * HASH_MULT;
    case (op)
      OP_LOAD: begin
        cmd_r     <= in_data.command;
        cur_key_r <= in_data.key[KW-1:0];
        cur_val_r <= in_data.value[VW-1:0];
      end
      OP_RD_A, OP_K_RD1: addr_a_r <= {1'b0, idx};
      OP_RD_B, OP_K_RD2: addr_b_r <= {1'b1, idx};
      OP_HASH_B: begin
        hit_a_r <= rd_r.valid && (rd_r.key == cur_key_r);
        val_a_r <= rd_r.val;
      end
      OP_PROBE: begin
        rounds_r     <= '0;
        res_found_r  <= probe_found;
        res_val_r    <= probe_val;
        res_status_r <= probe_status;
      end
      OP_K_EV1: begin
        if (!rd_r.valid) begin
          res_status_r <= ST_OK;
        end else begin
          tmp_key_r <= rd_r.key;
          tmp_val_r <= rd_r.val;
        end
      end
      OP_K_EV2: begin
        if (!rd_r.valid) begin
          res_status_r <= ST_OK;
        end else begin
          cur_key_r <= rd_r.key;
          cur_val_r <= rd_r.val;
          rounds_r  <= rounds_inc;
          if (stat.limit) res_status_r <= ST_STASHED;
        end
      end
      OP_OUT: begin
        out_data_r.status     <= res_status_r;
        out_data_r.found      <= res_found_r;
        out_data_r.read_value <= 32'(res_val_r);
      end
      default: rounds_r <= rounds_r;
    endcase
  end

endmodule

// ----- src/cuckoo_hash_table.sv -----
// Lookup, remove and rejected inserts load their result once the probe is done.
// Other inserts run displacement rounds until a slot is free or the kick limit is hit.
// Throughput: one request at a time; the next is accepted the cycle after a result loads.
// Reset: synchronous, active low; a clearing pass then writes every table entry
// (2*2^floor(log2(HALF_DEPTH)), 2048 by default) before the first request is accepted.
// ----------------------------------------------------------------------------
// cuckoo_hash_table
// Two-half cuckoo hash table with one-entry stash: insert, lookup, remove.
// ----------------------------------------------------------------------------
module cuckoo_hash_table #(
  parameter int HALF_DEPTH = 1024,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cht_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cht_pkg::rsp_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);
  import cht_pkg::*;

  op_t      op;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .op       (op)
  );

  cht_dp #(
    .HALF_DEPTH (HALF_DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_OUT |=> out_valid)
    else $error("result load did not raise out_valid");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.status == ST_OK)
    else $error("found result with non-ok status");
`endif

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Cuckoo hash table testbench
// Drives insert, lookup and remove requests through the valid/ready request
// port and checks every result against a behavioral table model kept in the
// bench. Salts and the kick limit are reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb;
  import cht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF = 1024;
  localparam int IB   = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cuckoo_hash_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [31:0] tbl_key [2*HALF];
  logic [31:0] tbl_val [2*HALF];
  bit tbl_used [2*HALF];
  logic [31:0] stash_k, stash_v;
  bit stash_used;
  logic [31:0] salt_a, salt_b;
  logic [10:0] kick_limit;

  rsp_t expected_q[$];
  logic [31:0] live_keys[$];
  int mismatches = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_stashed = 0;
  int n_full = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  int stall_pct = 20;

  function automatic logic [IB-1:0] hash_idx(logic [31:0] k, logic [31:0] s);
    logic [31:0] p;
    p = (k ^ s) * 32'h9E37_79B1;
    return p[31:32-IB];
  endfunction

  function automatic int home_a(logic [31:0] k);
    return hash_idx(k, salt_a);
  endfunction

  function automatic int home_b(logic [31:0] k);
    return HALF + hash_idx(k, salt_b);
  endfunction

  function automatic bit holds(int i, logic [31:0] k);
    return tbl_used[i] && tbl_key[i] == k;
  endfunction

  function automatic status_t table_insert(logic [31:0] k, logic [31:0] v);
    logic [31:0] ck, cv, tk, tv;
    int i1, i2, rounds, lim;
    if (holds(home_a(k), k) || holds(home_b(k), k) || (stash_used && stash_k == k))
      return ST_EXISTS;
    if (stash_used) return ST_FULL;
    ck = k; cv = v; rounds = 0;
    lim = (kick_limit == 0) ? 1 : kick_limit;
    forever begin
      i1 = home_a(ck);
      if (!tbl_used[i1]) begin
        tbl_used[i1] = 1; tbl_key[i1] = ck; tbl_val[i1] = cv;
        return ST_OK;
      end
      tk = tbl_key[i1]; tv = tbl_val[i1];
      tbl_key[i1] = ck; tbl_val[i1] = cv;
      i2 = home_b(tk);
      if (!tbl_used[i2]) begin
        tbl_used[i2] = 1; tbl_key[i2] = tk; tbl_val[i2] = tv;
        return ST_OK;
      end
      ck = tbl_key[i2]; cv = tbl_val[i2];
      tbl_key[i2] = tk; tbl_val[i2] = tv;
      rounds++;
      if (rounds >= lim) begin
        stash_used = 1; stash_k = ck; stash_v = cv;
        return ST_STASHED;
      end
    end
  endfunction

  function automatic rsp_t table_result(req_t r);
    rsp_t o;
    int a, b;
    o = '{status: ST_NOT_FOUND, found: 1'b0, read_value: '0};
    if (r.command == CMD_INSERT) begin
      o.status = table_insert(r.key, r.value);
    end else if (r.command == CMD_LOOKUP || r.command == CMD_REMOVE) begin
      a = home_a(r.key);
      b = home_b(r.key);
      if (holds(a, r.key)) begin
        o.found = 1; o.read_value = tbl_val[a];
        if (r.command == CMD_REMOVE) tbl_used[a] = 0;
      end else if (holds(b, r.key)) begin
        o.found = 1; o.read_value = tbl_val[b];
        if (r.command == CMD_REMOVE) tbl_used[b] = 0;
      end else if (stash_used && stash_k == r.key) begin
        o.found = 1; o.read_value = stash_v;
        if (r.command == CMD_REMOVE) stash_used = 0;
      end
      o.status = o.found ? ST_OK : ST_NOT_FOUND;
    end
    return o;
  endfunction

  task automatic gap();
    int n;
    if ($urandom_range(99) < stall_pct) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_request(cmd_t c, logic [31:0] k, logic [31:0] v);
    req_t r;
    r.command = c; r.key = k; r.value = v;
    gap();
    in_data <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(table_result(r));
    n_sent++;
    if (r.command == CMD_INSERT) live_keys.push_back(k);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SALT_FIRST: salt_a = d;
      REG_SALT_SECOND: salt_b = d;
      default: kick_limit = d[10:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    if (live_keys.size() != 0 && $urandom_range(1))
      return live_keys[$urandom_range(live_keys.size() - 1)];
    return $urandom();
  endfunction

  task automatic test_directed();
    send_request(CMD_LOOKUP, 32'h0, 32'h0);
    send_request(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_request(CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_request(CMD_INSERT, 32'h0, 32'h1234_5678);
    send_request(CMD_LOOKUP, 32'h0, 32'h0);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_REMOVE, 32'h0, 32'h0);
    send_request(CMD_LOOKUP, 32'h0, 32'h0);
    send_request(cmd_t'(2'd3), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_request(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
    drain();
  endtask

  // equal salts and kick limit 0 (taken as 1) force collisions into the stash quickly
  task automatic test_stash();
    logic [31:0] k;
    write_reg(REG_SALT_FIRST, 32'h0);
    write_reg(REG_SALT_SECOND, 32'h0);
    write_reg(REG_MAX_KICKS, 32'h0);
    live_keys.delete();
    for (int i = 0; i < 24; i++) begin
      k = i << 22;
      send_request(CMD_INSERT, k, ~k);
    end
    send_request(CMD_INSERT, 32'h0, 32'h5);
    send_request(CMD_LOOKUP, stash_k, 32'h0);
    send_request(CMD_REMOVE, stash_k, 32'h0);
    send_request(CMD_INSERT, 32'hABCD_0000, 32'h7);
    drain();
  endtask

  task automatic random_phase(int n, int ins_pct);
    int r;
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      k = pick_key();
      if (r < ins_pct) send_request(CMD_INSERT, k, $urandom());
      else if (r < ins_pct + (100 - ins_pct) / 2) send_request(CMD_LOOKUP, k, $urandom());
      else if (r < 98) send_request(CMD_REMOVE, k, $urandom());
      else send_request(cmd_t'(2'd3), k, $urandom());
      if (i == n / 2) drain();
    end
    drain();
  endtask

  task automatic test_random();
    write_reg(REG_SALT_FIRST, 32'hFFFF_FFFF);
    write_reg(REG_SALT_SECOND, 32'h8000_0001);
    write_reg(REG_MAX_KICKS, 32'd1024);
    live_keys.delete();
    random_phase(500, 60);
    stall_pct = 0;
    write_reg(REG_MAX_KICKS, 32'd3);
    random_phase(400, 70);
    stall_pct = 40;
    write_reg(REG_SALT_FIRST, $urandom());
    write_reg(REG_SALT_SECOND, $urandom());
    write_reg(REG_MAX_KICKS, 32'd1);
    random_phase(350, 50);
    stall_pct = 20;
    write_reg(REG_MAX_KICKS, 32'd64);
    random_phase(350, 40);
  endtask

  always @(negedge clk) begin
    if (stall_pct == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= stall_pct) ||
                      ($urandom_range(15) == 0 ? 1'b0 : 1'b0);
  end

  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (e.status == ST_STASHED) n_stashed++;
        if (e.status == ST_FULL) n_full++;
        if (out_data.status !== e.status || out_data.found !== e.found ||
            out_data.read_value !== e.read_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", e, out_data);
        end
      end
    end
  end

  // the 11-bit kick limit (at most 2047 kicks per insert) plus long stalls fit well within this
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 40000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 2 * HALF; i++) tbl_used[i] = 0;
    stash_used = 0; stash_k = '0; stash_v = '0;
    salt_a = 32'd1; salt_b = 32'd2; kick_limit = 11'd64;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_stash();
    test_random();
    $display("covered %0d requests, %0d results checked", n_sent, n_checked);
    $display("stash placements %0d, full rejections %0d", n_stashed, n_full);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
src/cht_pkg.sv
src/cht_ctrl.sv
src/cht_dp.sv
src/cuckoo_hash_table.sv
dv/tb.sv
